@@ hdl/wbpf_pkg.sv @@
// Shared types and constants for the wildcard byte pattern finder.
`timescale 1ns / 1ps
`default_nettype none

package wbpf_pkg;

    localparam int MAX_PATTERN_BYTES_DEF = 8;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 64;
    localparam int LEN_W     = 4;
    localparam int MASK_W    = 8;
    localparam int OFFSET_W  = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CARE_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_BYTES     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_KEEP_MASK = 3'd4;

    // Per-cell control, driven by the top level for every window cell.
    typedef struct packed {
        logic              shift_en;
        logic              flush;
        logic              clear;
        logic              in_use;
        logic              care;
        logic              keep;
        logic [BYTE_W-1:0] want;
        logic [BYTE_W-1:0] rep;
    } wbpf_cell_ctrl_t;

    // Per-cell status back to the top level.
    typedef struct packed {
        logic              hit_ok;
        logic [BYTE_W-1:0] out_byte;
        logic [BYTE_W-1:0] tap;
    } wbpf_cell_stat_t;

endpackage

`default_nettype wire

@@ hdl/wbpf_cell.sv @@
// One window cell: holds one recent byte and passes it on, and compares the byte arriving at it.
`timescale 1ns / 1ps
`default_nettype none

module wbpf_cell
    import wbpf_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [BYTE_W-1:0] byte_in,
    input  wire wbpf_cell_ctrl_t ctrl,
    output wbpf_cell_stat_t      stat
);

    logic [BYTE_W-1:0] window_reg;
    logic [BYTE_W-1:0] window_next;
    logic [BYTE_W-1:0] cur_byte;

    // A stream start empties the window before the new byte shifts in.
    assign cur_byte = ctrl.flush ? '0 : byte_in;

    always_comb begin
        window_next = window_reg;
        if (ctrl.clear) begin
            window_next = '0;
        end else if (ctrl.shift_en) begin
            window_next = cur_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else begin
            window_reg <= window_next;
        end
    end

    assign stat.hit_ok   = !ctrl.in_use || !ctrl.care || (cur_byte == ctrl.want);
    assign stat.out_byte = ctrl.keep ? ctrl.rep : cur_byte;
    assign stat.tap      = window_reg;

endmodule

`default_nettype wire

@@ hdl/wildcard_byte_pattern_finder_core.sv @@
// Top level of the wildcard byte pattern finder.
//
// Usage: bytes enter on the s_ channel (valid/ready), one per transaction,
// with s_stream_start marking the first byte of a stream and s_stream_end
// the last. The block keeps a chain of window cells, one per pattern byte,
// and compares the newest pattern_length bytes with the pattern under the
// care mask as each byte arrives. The first match of a stream yields one
// m_ transaction with m_found = 1, the start offset and the replacement
// word; a stream that ends with no match yields m_found = 0 with zero data.
// Configuration is written on the cfg_ channel, which is always ready.
// A result is registered and valid in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the only limit is the single output
// register, which is refilled in the same cycle that it is taken.
// A stalled receiver holds the result in the output register, and s_ready
// drops only while that register is full and m_ready is low.
// Reset clears the configuration to its defaults, the window, fill count,
// offset and match flag, and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_finder_core
    import wbpf_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data,

    input  wire logic                 s_valid,
    output      logic                 s_ready,
    input  wire logic [BYTE_W-1:0]    s_data_byte,
    input  wire logic                 s_stream_start,
    input  wire logic                 s_stream_end,

    output      logic                 m_valid,
    input  wire logic                 m_ready,
    output      logic                 m_found,
    output      logic [OFFSET_W-1:0]  m_match_offset,
    output      logic [WORD_W-1:0]    m_new_bytes
);

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN_BYTES);

    // Configuration registers.
    logic [WORD_W-1:0] pattern_reg;
    logic [MASK_W-1:0] care_reg;
    logic [LEN_W-1:0]  length_reg;
    logic [WORD_W-1:0] replace_reg;
    logic [MASK_W-1:0] keep_reg;

    // Stream state.
    logic [LEN_W-1:0]    fill_reg,   fill_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic                done_reg,   done_next;

    // Output register.
    logic                m_valid_reg,  m_valid_next;
    logic                m_found_reg;
    logic [OFFSET_W-1:0] m_offset_reg;
    logic [WORD_W-1:0]   m_bytes_reg;

    logic                accept;
    logic                done_eff;
    logic [LEN_W-1:0]    used_len;
    logic [LEN_W-1:0]    fill_base;
    logic [LEN_W-1:0]    fill_new;
    logic [OFFSET_W-1:0] here;
    logic [OFFSET_W-1:0] hit_offset;
    logic                hit_all;
    logic                hit;
    logic                emit;
    logic [WORD_W-1:0]   word;

    wbpf_cell_ctrl_t cell_ctrl [MAX_PATTERN_BYTES];
    wbpf_cell_stat_t cell_stat [MAX_PATTERN_BYTES];
    logic [2:0]      cell_pos  [MAX_PATTERN_BYTES];

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            care_reg    <= '1;
            length_reg  <= LEN_W'(1);
            replace_reg <= '0;
            keep_reg    <= '1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PATTERN_BYTES:     pattern_reg <= cfg_data;
                REG_PATTERN_CARE_MASK: care_reg    <= cfg_data[MASK_W-1:0];
                REG_PATTERN_LENGTH:    length_reg  <= cfg_data[LEN_W-1:0];
                REG_REPLACE_BYTES:     replace_reg <= cfg_data;
                REG_REPLACE_KEEP_MASK: keep_reg    <= cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Length outside the supported range is clamped.
    always_comb begin
        priority if (length_reg == '0) begin
            used_len = LEN_W'(1);
        end else if (length_reg > LEN_MAX) begin
            used_len = LEN_MAX;
        end else begin
            used_len = length_reg;
        end
    end

    assign done_eff  = done_reg && !s_stream_start;
    assign fill_base = s_stream_start ? '0 : fill_reg;
    assign fill_new  = (fill_base == LEN_MAX) ? fill_base : fill_base + LEN_W'(1);
    assign here      = s_stream_start ? '0 : offset_reg;

    // Cell k holds the k-th newest byte and lines up with pattern byte len-1-k.
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
        logic [LEN_W-1:0] pos_full;

        assign pos_full    = used_len - LEN_W'(1) - LEN_W'(k);
        assign cell_pos[k] = pos_full[2:0];

        assign cell_ctrl[k].shift_en = accept && !done_eff;
        assign cell_ctrl[k].flush    = (k != 0) && s_stream_start;
        assign cell_ctrl[k].clear    = accept && s_stream_end;
        assign cell_ctrl[k].in_use   = LEN_W'(k) < used_len;
        assign cell_ctrl[k].care     = care_reg[cell_pos[k]];
        assign cell_ctrl[k].keep     = keep_reg[cell_pos[k]];
        assign cell_ctrl[k].want     = pattern_reg[{cell_pos[k], 3'b000} +: BYTE_W];
        assign cell_ctrl[k].rep      = replace_reg[{cell_pos[k], 3'b000} +: BYTE_W];

        if (k == 0) begin : g_head
            wbpf_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .byte_in (s_data_byte),
                .ctrl    (cell_ctrl[k]),
                .stat    (cell_stat[k])
            );
        end else begin : g_body
            wbpf_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .byte_in (cell_stat[k-1].tap),
                .ctrl    (cell_ctrl[k]),
                .stat    (cell_stat[k])
            );
        end
    end

    always_comb begin
        hit_all = 1'b1;
        word    = '0;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            hit_all = hit_all && cell_stat[k].hit_ok;
            if (cell_ctrl[k].in_use) begin
                word[{cell_pos[k], 3'b000} +: BYTE_W] = cell_stat[k].out_byte;
            end
        end
    end

    assign hit        = !done_eff && (fill_new >= used_len) && hit_all;
    assign emit       = accept && !done_eff && (hit || s_stream_end);
    assign hit_offset = (here == OFFSET_MAX) ? OFFSET_MAX
                                             : here - OFFSET_W'(used_len) + OFFSET_W'(1);

    always_comb begin
        fill_next   = fill_reg;
        offset_next = offset_reg;
        done_next   = done_reg;
        if (accept) begin
            priority if (s_stream_end) begin
                fill_next   = '0;
                offset_next = '0;
                done_next   = 1'b0;
            end else if (!done_eff) begin
                fill_next   = fill_new;
                offset_next = (here == OFFSET_MAX) ? here : here + OFFSET_W'(1);
                done_next   = hit;
            end else begin
                fill_next   = fill_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            offset_reg <= '0;
            done_reg   <= 1'b0;
        end else begin
            fill_reg   <= fill_next;
            offset_reg <= offset_next;
            done_reg   <= done_next;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_found_reg  <= hit;
            m_offset_reg <= hit ? hit_offset : '0;
            m_bytes_reg  <= hit ? word : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_match_offset = m_offset_reg;
    assign m_new_bytes    = m_bytes_reg;

    // A reported match implies the window holds at least one byte.
    a_done_has_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> fill_reg != '0)
        else $error("match flag set with an empty window");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= LEN_MAX)
        else $error("window fill count beyond the window depth");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_stream_end) |=> (fill_reg == '0 && offset_reg == '0 && !done_reg))
        else $error("stream state not cleared after the last byte");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_offset_reg == '0 && m_bytes_reg == '0))
        else $error("not-found result carries nonzero data");

endmodule

`default_nettype wire

@@ sim/wildcard_byte_pattern_finder_core_tb.sv @@
// Self-checking testbench for the wildcard byte pattern finder core.
`timescale 1ns / 1ps

module wildcard_byte_pattern_finder_core_tb
    import wbpf_pkg::*;
();

    localparam int     CLK_HALF_NS   = 5;
    localparam int     RESET_CYCLES  = 10;
    localparam int     RANDOM_ITEMS  = 1650;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     MAX_REPORTS   = 10;
    localparam longint LIMIT_NS      = 2_000_000;
    localparam int     WIN_DEPTH     = MAX_PATTERN_BYTES_DEF;
    localparam int     LEN_RAW_MAX   = (1 << LEN_W) - 1;
    localparam int     IDX_LAST      = (1 << CFG_IDX_W) - 1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_REPLACE_KEEP_MASK + 1'b1;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] offset;
        logic [WORD_W-1:0]   new_bytes;
    } search_report_t;

    logic                 aclk;
    logic                 aresetn        = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [WORD_W-1:0]    cfg_data       = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_data_byte    = '0;
    logic                 s_stream_start = 1'b0;
    logic                 s_stream_end   = 1'b0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic                 m_found;
    logic [OFFSET_W-1:0]  m_match_offset;
    logic [WORD_W-1:0]    m_new_bytes;

    // Mirror of the configuration registers, at their reset values.
    logic [WORD_W-1:0]    cfg_pattern = '0;
    logic [MASK_W-1:0]    cfg_care    = '1;
    logic [LEN_W-1:0]     cfg_len     = LEN_W'(1);
    logic [WORD_W-1:0]    cfg_replace = '0;
    logic [MASK_W-1:0]    cfg_keep    = '1;

    // Mirror of the search state.
    logic [BYTE_W-1:0]    win [WIN_DEPTH];
    int                   win_fill;
    logic [OFFSET_W-1:0]  stream_offset;
    logic                 stream_matched;

    search_report_t       pending_reports [$];
    search_report_t       expected_rpt;

    int src_idle_pct  = 33;
    int dst_idle_pct  = 49;
    int hold_requests = 0;
    int hold_served   = 0;
    logic hold_active = 1'b0;

    int fail_count     = 0;
    int items_sent     = 0;
    int streams_ended  = 0;
    int cfg_writes     = 0;
    int matches_seen   = 0;
    int misses_seen    = 0;

    wildcard_byte_pattern_finder_core #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES_DEF)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_stream_start(s_stream_start),
        .s_stream_end  (s_stream_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_match_offset(m_match_offset),
        .m_new_bytes   (m_new_bytes)
    );

    always begin
        aclk = 1'b0;
        #CLK_HALF_NS;
        aclk = 1'b1;
        #CLK_HALF_NS;
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    function automatic int effective_len(input logic [LEN_W-1:0] raw);
        int n;
        n = int'(raw);
        if (n < 1) n = 1;
        if (n > WIN_DEPTH) n = WIN_DEPTH;
        return n;
    endfunction

    task automatic clear_stream_state();
        int k;
        for (k = 0; k < WIN_DEPTH; k++) win[k] = '0;
        win_fill       = 0;
        stream_offset  = '0;
        stream_matched = 1'b0;
    endtask

    task automatic mirror_config(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        case (idx)
            REG_PATTERN_BYTES:     cfg_pattern = data;
            REG_PATTERN_CARE_MASK: cfg_care    = data[MASK_W-1:0];
            REG_PATTERN_LENGTH:    cfg_len     = data[LEN_W-1:0];
            REG_REPLACE_BYTES:     cfg_replace = data;
            REG_REPLACE_KEEP_MASK: cfg_keep    = data[MASK_W-1:0];
            default: ;
        endcase
    endtask

    // Advances the search mirror by one byte and queues the result it causes, if any.
    task automatic predict_search_step(input logic [BYTE_W-1:0] data, input logic is_first,
                                       input logic is_last);
        int                  len;
        int                  k;
        logic                hit;
        logic                reported;
        logic [WORD_W-1:0]   word;
        logic [BYTE_W-1:0]   got;
        logic [BYTE_W-1:0]   rep;
        logic [OFFSET_W-1:0] here;
        search_report_t      rpt;
        reported = 1'b0;
        if (is_first) clear_stream_state();
        if (!stream_matched) begin
            len  = effective_len(cfg_len);
            here = stream_offset;
            for (k = WIN_DEPTH - 1; k > 0; k--) win[k] = win[k-1];
            win[0] = data;
            if (win_fill < WIN_DEPTH) win_fill++;
            if (stream_offset != OFFSET_MAX) stream_offset++;
            if (win_fill >= len) begin
                hit  = 1'b1;
                word = '0;
                for (k = 0; k < len; k++) begin
                    got = win[len-1-k];
                    rep = cfg_replace[BYTE_W*k +: BYTE_W];
                    if (cfg_care[k] && got != cfg_pattern[BYTE_W*k +: BYTE_W]) hit = 1'b0;
                    if (!cfg_keep[k]) rep = got;
                    word[BYTE_W*k +: BYTE_W] = rep;
                end
                if (hit) begin
                    stream_matched = 1'b1;
                    rpt.found      = 1'b1;
                    rpt.offset     = (here == OFFSET_MAX) ? OFFSET_MAX : here - (len - 1);
                    rpt.new_bytes  = word;
                    pending_reports.push_back(rpt);
                    reported = 1'b1;
                end
            end
            if (!reported && is_last) begin
                rpt = '0;
                pending_reports.push_back(rpt);
            end
        end
        if (is_last) clear_stream_state();
    endtask

    // Valid stays high after acceptance; it is lowered only when the sender idles or stops.
    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic is_first,
                             input logic is_last);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= data;
        s_stream_start <= is_first;
        s_stream_end   <= is_last;
        do @(posedge aclk); while (!s_ready);
        predict_search_step(data, is_first, is_last);
        items_sent++;
        if (is_last) streams_ended++;
    endtask

    task automatic send_word_stream(input logic [WORD_W-1:0] bytes_word, input int count,
                                    input logic mark_start, input logic mark_end);
        int i;
        for (i = 0; i < count; i++) begin
            send_byte(bytes_word[BYTE_W*i +: BYTE_W], mark_start && i == 0,
                      mark_end && i == count - 1);
        end
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        mirror_config(idx, data);
        cfg_writes++;
    endtask

    // Writes every register, with random upper data bits on the narrow ones, plus one
    // unmapped index. Only called once the block has gone idle.
    task automatic load_config(input logic [WORD_W-1:0] pattern, input logic [MASK_W-1:0] care,
                               input logic [LEN_W-1:0] len, input logic [WORD_W-1:0] replace,
                               input logic [MASK_W-1:0] keep);
        logic [WORD_W-1:0]    junk;
        logic [CFG_IDX_W-1:0] spare_idx;
        wait_drain();
        junk      = {$urandom, $urandom};
        spare_idx = REG_FIRST_UNUSED +
                    CFG_IDX_W'($urandom_range(0, IDX_LAST - REG_FIRST_UNUSED));
        write_reg(REG_PATTERN_BYTES, pattern);
        write_reg(REG_PATTERN_CARE_MASK, {junk[WORD_W-1:MASK_W], care});
        write_reg(REG_PATTERN_LENGTH, {junk[WORD_W-1:LEN_W], len});
        write_reg(REG_REPLACE_BYTES, replace);
        write_reg(REG_REPLACE_KEEP_MASK, {junk[WORD_W-1:MASK_W], keep});
        write_reg(spare_idx, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [MASK_W-1:0] random_mask();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 3) return '0;
        if (pick < 6) return '1;
        return MASK_W'($urandom);
    endfunction

    // Mostly well-formed streams, often with the pattern planted inside; the rest carry
    // random flags or a restart in the middle and may never end.
    task automatic send_random_stream();
        int                n;
        int                len;
        int                pos;
        int                kind;
        int                brk;
        int                j;
        int                sel;
        logic              use_plant;
        logic              narrow;
        logic              first_flag;
        logic              last_flag;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] planted [WIN_DEPTH];
        kind      = $urandom_range(0, 99);
        n         = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 20) : $urandom_range(21, 120);
        len       = effective_len(cfg_len);
        use_plant = ($urandom_range(0, 99) < 60);
        narrow    = ($urandom_range(0, 99) < 30);
        if (use_plant && n < len) n = len;
        pos = use_plant ? $urandom_range(0, n - len) : 0;
        brk = $urandom_range(0, n - 1);
        for (j = 0; j < WIN_DEPTH; j++) begin
            planted[j] = cfg_care[j] ? cfg_pattern[BYTE_W*j +: BYTE_W] : BYTE_W'($urandom);
        end
        for (j = 0; j < n; j++) begin
            sel = $urandom_range(0, WIN_DEPTH - 1);
            if (use_plant && j >= pos && j < pos + len) begin
                data = planted[j-pos];
            end else if (narrow) begin
                data = cfg_pattern[BYTE_W*sel +: BYTE_W];
            end else begin
                data = BYTE_W'($urandom);
            end
            if (kind < 80) begin
                first_flag = (j == 0);
                last_flag  = (j == n - 1);
            end else if (kind < 90) begin
                first_flag = ($urandom_range(0, 19) == 0);
                last_flag  = ($urandom_range(0, 19) == 0);
            end else begin
                first_flag = (j == brk);
                last_flag  = (kind % 2 == 0) && (j == n - 1);
            end
            send_byte(data, first_flag, last_flag);
        end
    endtask

    // Receiver: random stalls, or a long hold-off while one is requested.
    always @(posedge aclk) begin
        if (hold_active) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                note_failure($sformatf("unexpected result: found=%0b offset=%0d bytes=%h",
                                       m_found, m_match_offset, m_new_bytes));
            end else begin
                expected_rpt = pending_reports.pop_front();
                if (m_found !== expected_rpt.found || m_match_offset !== expected_rpt.offset ||
                    m_new_bytes !== expected_rpt.new_bytes) begin
                    note_failure($sformatf({"result mismatch: expected found=%0b offset=%0d ",
                                            "bytes=%h, got found=%0b offset=%0d bytes=%h"},
                                           expected_rpt.found, expected_rpt.offset,
                                           expected_rpt.new_bytes, m_found, m_match_offset,
                                           m_new_bytes));
                end else if (m_found) begin
                    matches_seen++;
                end else begin
                    misses_seen++;
                end
            end
        end
    end

    // Reset values: a single zero byte is searched for. The byte after the match and the
    // stream end give nothing; a stream without a zero reports not found.
    task automatic test_reset_defaults();
        send_word_stream(64'h22_00_11, 3, 1'b1, 1'b1);
        send_word_stream(64'h7E_FF, 2, 1'b1, 1'b1);
    endtask

    // Eight-byte pattern with two don't-care bytes and two copied bytes, matched on the
    // last byte of the stream.
    task automatic test_full_length_wildcards();
        load_config(64'h88_77_66_55_44_33_22_11, 8'b1101_1110, 4'd8, '1, 8'b0111_1110);
        send_byte(8'hAB, 1'b1, 1'b0);
        send_word_stream(64'h88_77_FF_55_44_33_22_00, 8, 1'b0, 1'b1);
    endtask

    // Length zero acts as one, with mask and pattern bits above it ignored and a restart
    // in the middle of a stream; then a length above the maximum with nothing compared,
    // on a stream that begins without a start flag.
    task automatic test_length_clamp_and_restart();
        load_config(64'hFFFF_FFFF_FFFF_FF5A, 8'hFF, 4'd0, '1, 8'h00);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h5A, 1'b1, 1'b1);
        load_config('0, 8'h00, LEN_W'(LEN_RAW_MAX), 64'h0123_4567_89AB_CDEF, 8'hA5);
        send_word_stream(64'hF0E1_D2C3_B4A5_9687, 8, 1'b0, 1'b1);
    endtask

    // Every one-byte stream matches, so results pile up behind a stalled receiver and the
    // input has to stall as well.
    task automatic test_output_backpressure();
        int i;
        load_config(random_word(), 8'h00, 4'd1, random_word(), random_mask());
        src_idle_pct = 0;
        dst_idle_pct <= 0;
        hold_requests <= hold_requests + 1;
        for (i = 0; i < 40; i++) begin
            send_byte(BYTE_W'($urandom), 1'b1, 1'b1);
        end
        wait_drain();
    endtask

    task automatic test_random_streams(input int src_pct, input int dst_pct, input int budget);
        int                stop_at;
        int                streams_here;
        int                pick;
        logic [LEN_W-1:0]  len;
        src_idle_pct = src_pct;
        dst_idle_pct <= dst_pct;
        stop_at      = items_sent + budget;
        streams_here = 0;
        while (items_sent < stop_at) begin
            if (streams_here % 10 == 0) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) len = '0;
                else if (pick < 3) len = LEN_W'($urandom_range(WIN_DEPTH + 1, LEN_RAW_MAX));
                else if (pick < 6) len = LEN_W'(1);
                else if (pick < 9) len = LEN_W'(WIN_DEPTH);
                else len = LEN_W'($urandom_range(1, WIN_DEPTH));
                load_config(random_word(), random_mask(), len, random_word(), random_mask());
            end
            send_random_stream();
            streams_here++;
        end
    endtask

    initial begin
        clear_stream_state();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_full_length_wildcards();
        test_length_clamp_and_restart();
        test_random_streams(33, 49, RANDOM_ITEMS / 3);
        test_output_backpressure();
        test_random_streams(49, 33, RANDOM_ITEMS / 3);
        test_random_streams(0, 0, RANDOM_ITEMS / 3);
        wait_drain();
        $display("Sent %0d bytes closing %0d streams, with %0d register writes.",
                 items_sent, streams_ended, cfg_writes);
        $display("Checked %0d matches and %0d not-found results; %0d failures.",
                 matches_seen, misses_seen, fail_count);
        if (fail_count == 0) begin
            $display("[wildcard_byte_pattern_finder_core] OK");
        end else begin
            $display("[wildcard_byte_pattern_finder_core] ERROR");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("Timed out with %0d results still expected.", pending_reports.size());
        $display("[wildcard_byte_pattern_finder_core] ERROR");
        $finish;
    end

endmodule
